// ----- hdl/srgb_linear_converter_assert.svh -----
// Assertion macros for the sRGB / linear converter.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SRGB_LINEAR_CONVERTER_ASSERT_SVH
`define SRGB_LINEAR_CONVERTER_ASSERT_SVH
`ifndef SYNTH
`define SLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SLC_ASSERT_IF(lbl, cond, prop, msg) `SLC_ASSERT(lbl, (cond) |-> (prop), msg)
`define SLC_ASSERT_NEXT(lbl, cond, prop, msg) `SLC_ASSERT(lbl, (cond) |=> (prop), msg)
`else
`define SLC_ASSERT(lbl, prop, msg)
`define SLC_ASSERT_IF(lbl, cond, prop, msg)
`define SLC_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

// ----- hdl/slc_pkg.sv -----
// Shared types, constants and curve tables of the sRGB / linear converter.
// No dependencies; the tables are built at elaboration.
package slc_pkg;

  localparam int LIN_BITS = 16;   // linear precision, 10..16
  localparam int FIELD_W  = 16;   // width of the linear ports
  localparam int SRGB_W   = 8;
  localparam int LUMA_W   = 16;
  localparam int N_CODES  = 256;
  localparam int NSTG     = 4;    // register stages, input to output

  localparam longint L_INT    = (longint'(1) << LIN_BITS) - 1;
  localparam longint VLIN_MAX = (31308 * L_INT) / 10000000;  // top of linear segment

  typedef logic [LIN_BITS-1:0] lin_t;
  typedef logic [SRGB_W-1:0]   srgb_t;
  typedef lin_t lin_tab_t [N_CODES];

  localparam lin_t LIN_MAX = LIN_BITS'(L_INT);

  typedef struct packed {
    lin_t r;
    lin_t g;
    lin_t b;
  } lin_rgb_t;

  // stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } load_t;

  // Rec.709 weights in Q0.16
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;

  localparam int PROD_W  = LIN_BITS + 16;
  localparam int SUM_W   = LIN_BITS + 17;
  localparam int FOLD_SH = LIN_BITS + 1;   // 2L = 2^FOLD_SH - 2
  localparam int REM_W   = 18;

  localparam logic [REM_W-1:0] FOLD_MASK = REM_W'((longint'(1) << FOLD_SH) - 1);
  localparam logic [REM_W-1:0] DIV_D     = REM_W'(2 * L_INT);

  // decode: round-half-up of L * f(c/255)
  function automatic lin_tab_t build_dec_tab();
    lin_tab_t tab;
    longint   y;
    real      x;
    real      t;
    for (int c = 0; c < N_CODES; c++) begin
      if (c <= 10) begin
        y = (20 * L_INT * c + 32946) / 65892;
      end else begin
        x = real'(40 * c + 561) / 10761.0;
        t = real'(L_INT) * (x ** 2.4);
        y = longint'($rtoi(t + 0.5));
      end
      tab[c] = LIN_BITS'(y);
    end
    return tab;
  endfunction

  // encode: smallest linear code that yields sRGB code k or more
  function automatic lin_tab_t build_enc_thr();
    lin_tab_t tab;
    longint   y;
    longint   tl;
    real      x;
    real      t;
    tab[0] = '0;
    for (int k = 1; k < N_CODES; k++) begin
      tl = (20 * L_INT * k - 10 * L_INT + 65891) / 65892;
      if (tl <= VLIN_MAX) begin
        y = tl;
      end else begin
        x = real'(40 * k + 541) / 10761.0;
        t = real'(L_INT) * (x ** 2.4);
        y = longint'($rtoi(t));
        if (real'(y) < t) begin
          y = y + 1;
        end
        if (y <= VLIN_MAX) begin
          y = VLIN_MAX + 1;
        end
      end
      tab[k] = LIN_BITS'(y);
    end
    return tab;
  endfunction

  localparam lin_tab_t DEC_TAB = build_dec_tab();
  localparam lin_tab_t ENC_THR = build_enc_thr();

  function automatic lin_t sat_lin(logic [FIELD_W-1:0] v);
    if (v > FIELD_W'(LIN_MAX)) begin
      return LIN_MAX;
    end
    return LIN_BITS'(v);
  endfunction

  // one step of the threshold search: try setting bit b of the code
  function automatic srgb_t enc_step(srgb_t p, logic [2:0] b, lin_t v);
    srgb_t cand;
    cand = p | (srgb_t'(1) << b);
    return (ENC_THR[cand] <= v) ? cand : p;
  endfunction

endpackage

// ----- hdl/slc_enc_chan.sv -----
// One channel of the linear to sRGB encoder: binary search over the
// threshold table, two code bits per stage. Uses slc_pkg.
module slc_enc_chan import slc_pkg::*; (
  input  logic  clk_i,
  input  load_t load_i,
  input  lin_t  lin_i,
  output srgb_t code_o
);

  logic [NSTG-1:0] ld;
  lin_t  v_q [NSTG-1];
  srgb_t p_q [NSTG];

  assign ld = {load_i.s4, load_i.s3, load_i.s2, load_i.s1};

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    lin_t  v_in;
    srgb_t p_in;
    srgb_t p_mid;
    srgb_t p_d;

    if (s == 0) begin : g_first
      assign v_in = lin_i;
      assign p_in = '0;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign p_in = p_q[s-1];
    end

    assign p_mid = enc_step(p_in, 3'(7 - 2 * s), v_in);
    assign p_d   = enc_step(p_mid, 3'(6 - 2 * s), v_in);

    always_ff @(posedge clk_i) begin
      if (ld[s]) begin
        p_q[s] <= p_d;
      end
    end

    // the last stage has no further use for the value
    if (s < NSTG - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (ld[s]) begin
          v_q[s] <= v_in;
        end
      end
    end
  end

  assign code_o = p_q[NSTG-1];

endmodule

// ----- hdl/slc_luma.sv -----
// Rec.709 luminance of three linear codes: weight products, sum, then
// division by 2L by folding on 2^(LIN_BITS+1). Uses slc_pkg.
module slc_luma import slc_pkg::*; (
  input  logic              clk_i,
  input  load_t             load_i,
  input  lin_rgb_t          lin_i,
  output logic [LUMA_W-1:0] luma_o
);

  logic [PROD_W-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  num;
  logic [LUMA_W-1:0] q1_d, q1_q;
  logic [REM_W-1:0]  r1_d, r1_q;
  logic [REM_W-1:0]  q2, r2, q3, r3;
  logic              q4;
  logic [LUMA_W:0]   y;
  logic [LUMA_W-1:0] luma_d, luma_q;

  always_ff @(posedge clk_i) begin
    if (load_i.s2) begin
      prod_r_q <= PROD_W'(lin_i.r) * PROD_W'(W_RED);
      prod_g_q <= PROD_W'(lin_i.g) * PROD_W'(W_GREEN);
      prod_b_q <= PROD_W'(lin_i.b) * PROD_W'(W_BLUE);
    end
  end

  // num = 2s + L; num = q1 * 2L + (low bits + 2 q1)
  always_comb begin
    sum  = SUM_W'(prod_r_q) + SUM_W'(prod_g_q) + SUM_W'(prod_b_q);
    num  = (sum << 1) + SUM_W'(L_INT);
    q1_d = LUMA_W'(num >> FOLD_SH);
    r1_d = REM_W'(num[FOLD_SH-1:0]) + (REM_W'(q1_d) << 1);
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s3) begin
      q1_q <= q1_d;
      r1_q <= r1_d;
    end
  end

  always_comb begin
    q2     = r1_q >> FOLD_SH;
    r2     = (r1_q & FOLD_MASK) + (q2 << 1);
    q3     = r2 >> FOLD_SH;
    r3     = (r2 & FOLD_MASK) + (q3 << 1);
    q4     = (r3 >= DIV_D);
    y      = (LUMA_W + 1)'(q1_q) + (LUMA_W + 1)'(q2) + (LUMA_W + 1)'(q3)
           + (LUMA_W + 1)'(q4);
    luma_d = y[LUMA_W] ? '1 : y[LUMA_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s4) begin
      luma_q <= luma_d;
    end
  end

  assign luma_o = luma_q;

endmodule

// ----- hdl/srgb_linear_converter.sv -----
// sRGB / linear pixel converter. One pixel per clock: a new transaction is
// taken every cycle while the output is not stalled, and each result passes
// through four register stages after its input is accepted: decode table
// look-up and the first encode search bits, the luminance weight multipliers,
// the luminance sum and first division fold, then the last division folds and
// the final encode bits. Each stage holds its transaction under back-pressure
// and refills as soon as it empties, so bubbles are squeezed out.
`include "srgb_linear_converter_assert.svh"

module srgb_linear_converter import slc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [SRGB_W-1:0]  srgb_red_i,
  input  logic [SRGB_W-1:0]  srgb_green_i,
  input  logic [SRGB_W-1:0]  srgb_blue_i,
  input  logic [FIELD_W-1:0] lin_red_i,
  input  logic [FIELD_W-1:0] lin_green_i,
  input  logic [FIELD_W-1:0] lin_blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               mode_echo_o,
  output logic [FIELD_W-1:0] out_lin_red_o,
  output logic [FIELD_W-1:0] out_lin_green_o,
  output logic [FIELD_W-1:0] out_lin_blue_o,
  output logic [SRGB_W-1:0]  out_srgb_red_o,
  output logic [SRGB_W-1:0]  out_srgb_green_o,
  output logic [SRGB_W-1:0]  out_srgb_blue_o,
  output logic [LUMA_W-1:0]  luminance_o
);

  logic [NSTG-1:0] valid_d, valid_q;
  logic [NSTG:0]   rdy;
  load_t           load;
  logic            cmd_q [NSTG];
  lin_rgb_t        lin_q [NSTG];
  lin_rgb_t        lin_sat;
  lin_rgb_t        lin_d;
  srgb_t           code_r, code_g, code_b;
  logic [LUMA_W-1:0] luma;

  // a stage takes new data when empty or when its successor moves on
  always_comb begin
    rdy[NSTG] = !out_stall_i;
    for (int s = NSTG - 1; s >= 0; s--) begin
      rdy[s] = !valid_q[s] || rdy[s+1];
    end
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int s = 1; s < NSTG; s++) begin
      valid_d[s] = rdy[s] ? valid_q[s-1] : valid_q[s];
    end
  end

  assign load = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    lin_sat.r = sat_lin(lin_red_i);
    lin_sat.g = sat_lin(lin_green_i);
    lin_sat.b = sat_lin(lin_blue_i);
    if (cmd_i) begin
      lin_d = lin_sat;
    end else begin
      lin_d.r = DEC_TAB[srgb_red_i];
      lin_d.g = DEC_TAB[srgb_green_i];
      lin_d.b = DEC_TAB[srgb_blue_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      cmd_q[0] <= cmd_i;
      lin_q[0] <= lin_d;
    end
    for (int s = 1; s < NSTG; s++) begin
      if (rdy[s]) begin
        cmd_q[s] <= cmd_q[s-1];
        lin_q[s] <= lin_q[s-1];
      end
    end
  end

  slc_enc_chan u_enc_r (
    .clk_i  (clk_i),
    .load_i (load),
    .lin_i  (lin_sat.r),
    .code_o (code_r)
  );

  slc_enc_chan u_enc_g (
    .clk_i  (clk_i),
    .load_i (load),
    .lin_i  (lin_sat.g),
    .code_o (code_g)
  );

  slc_enc_chan u_enc_b (
    .clk_i  (clk_i),
    .load_i (load),
    .lin_i  (lin_sat.b),
    .code_o (code_b)
  );

  slc_luma u_luma (
    .clk_i  (clk_i),
    .load_i (load),
    .lin_i  (lin_q[0]),
    .luma_o (luma)
  );

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = valid_q[NSTG-1];
  assign mode_echo_o = cmd_q[NSTG-1];

  assign out_lin_red_o   = cmd_q[NSTG-1] ? '0 : FIELD_W'(lin_q[NSTG-1].r);
  assign out_lin_green_o = cmd_q[NSTG-1] ? '0 : FIELD_W'(lin_q[NSTG-1].g);
  assign out_lin_blue_o  = cmd_q[NSTG-1] ? '0 : FIELD_W'(lin_q[NSTG-1].b);

  assign out_srgb_red_o   = cmd_q[NSTG-1] ? code_r : '0;
  assign out_srgb_green_o = cmd_q[NSTG-1] ? code_g : '0;
  assign out_srgb_blue_o  = cmd_q[NSTG-1] ? code_b : '0;

  assign luminance_o = luma;

  `SLC_ASSERT(a_stall_full, in_stall_o |-> (&valid_q), "input stalled with a free stage")
  `SLC_ASSERT_NEXT(a_acc_enters, in_valid_i && !in_stall_o, valid_q[0], "accepted transaction lost")
  `SLC_ASSERT_IF(a_enc_no_lin, out_valid_o && mode_echo_o, out_lin_red_o == '0 && out_lin_green_o == '0 && out_lin_blue_o == '0, "linear fields set in encode")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for srgb_linear_converter: decode and encode pixels with
// random source gaps and sink stalls, each result checked against an exact integer predictor.
// Depends on slc_pkg and the converter RTL only.
`timescale 1ns / 100ps

module tb_top import slc_pkg::*; ();

  localparam longint unsigned LIN_FULL  = L_INT;
  localparam int unsigned     CYCLE_CAP = 400000;
  localparam int unsigned     DRAIN     = 4 * NSTG;

  typedef enum bit {
    CMD_DECODE = 1'b0,
    CMD_ENCODE = 1'b1
  } pixel_cmd_e;

  typedef bit [319:0] wide_t;

  typedef struct {
    pixel_cmd_e         cmd;
    logic [SRGB_W-1:0]  srgb_r;
    logic [SRGB_W-1:0]  srgb_g;
    logic [SRGB_W-1:0]  srgb_b;
    logic [FIELD_W-1:0] lin_r;
    logic [FIELD_W-1:0] lin_g;
    logic [FIELD_W-1:0] lin_b;
  } pixel_in_t;

  typedef struct {
    int unsigned mode;
    int unsigned lin_r;
    int unsigned lin_g;
    int unsigned lin_b;
    int unsigned srgb_r;
    int unsigned srgb_g;
    int unsigned srgb_b;
    int unsigned luma;
  } pixel_out_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               cmd;
  logic [SRGB_W-1:0]  srgb_red;
  logic [SRGB_W-1:0]  srgb_green;
  logic [SRGB_W-1:0]  srgb_blue;
  logic [FIELD_W-1:0] lin_red;
  logic [FIELD_W-1:0] lin_green;
  logic [FIELD_W-1:0] lin_blue;
  logic               out_valid;
  logic               out_stall;
  logic               mode_echo;
  logic [FIELD_W-1:0] out_lin_red;
  logic [FIELD_W-1:0] out_lin_green;
  logic [FIELD_W-1:0] out_lin_blue;
  logic [SRGB_W-1:0]  out_srgb_red;
  logic [SRGB_W-1:0]  out_srgb_green;
  logic [SRGB_W-1:0]  out_srgb_blue;
  logic [LUMA_W-1:0]  luminance;

  pixel_out_t  expected_pixels[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          no_gaps;

  srgb_linear_converter DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cmd_i            (cmd),
    .srgb_red_i       (srgb_red),
    .srgb_green_i     (srgb_green),
    .srgb_blue_i      (srgb_blue),
    .lin_red_i        (lin_red),
    .lin_green_i      (lin_green),
    .lin_blue_i       (lin_blue),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .mode_echo_o      (mode_echo),
    .out_lin_red_o    (out_lin_red),
    .out_lin_green_o  (out_lin_green),
    .out_lin_blue_o   (out_lin_blue),
    .out_srgb_red_o   (out_srgb_red),
    .out_srgb_green_o (out_srgb_green),
    .out_srgb_blue_o  (out_srgb_blue),
    .luminance_o      (luminance)
  );

  // ---------------------------------------------------------------- predictor

  // a^ea * b^eb, wide enough for the curve comparisons (about 250 bits)
  function automatic wide_t power_product(longint unsigned a, int ea,
                                          longint unsigned b, int eb);
    wide_t acc;
    acc = 1;
    for (int i = 0; i < ea; i++) acc = acc * a;
    for (int i = 0; i < eb; i++) acc = acc * b;
    return acc;
  endfunction

  function automatic int unsigned srgb_to_linear(int unsigned code);
    wide_t       bound;
    wide_t       probe;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (code <= 10) begin
      return int'((20 * LIN_FULL * code + 32946) / 65892);
    end
    // largest y with (y - 1/2) <= L * ((40c + 561) / 10761)^2.4
    bound = power_product(2 * LIN_FULL, 5, 40 * code + 561, 12);
    lo = 0;
    hi = int'(LIN_FULL);
    while (lo < hi) begin
      mid   = lo + (hi - lo + 1) / 2;
      probe = power_product(2 * mid - 1, 5, 10761, 12);
      if (probe <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic int unsigned linear_to_srgb(int unsigned v);
    wide_t           bound;
    wide_t           probe;
    longint unsigned k;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    if (v > LIN_FULL) v = int'(LIN_FULL);
    if (longint'(v) * 10000000 <= 31308 * LIN_FULL) begin
      k = (65892 * longint'(v) + 10 * LIN_FULL) / (20 * LIN_FULL);
      return (k > 255) ? 255 : int'(k);
    end
    // largest k with (40k + 541) / 10761 <= (v / L)^(5/12)
    bound = power_product(v, 5, 10761, 12);
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid   = lo + (hi - lo + 1) / 2;
      probe = power_product(40 * mid + 541, 12, LIN_FULL, 5);
      if (probe <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic int unsigned rec709_luma(int unsigned r, int unsigned g, int unsigned b);
    longint unsigned s;
    longint unsigned y;
    s = 13933 * longint'(r) + 46871 * longint'(g) + 4732 * longint'(b);
    y = (2 * s + LIN_FULL) / (2 * LIN_FULL);
    return (y > 65535) ? 65535 : int'(y);
  endfunction

  function automatic pixel_out_t predict_pixel(pixel_in_t px);
    pixel_out_t res;
    res = '{default: 0};
    res.mode = int'(px.cmd);
    if (px.cmd == CMD_DECODE) begin
      res.lin_r = srgb_to_linear(px.srgb_r);
      res.lin_g = srgb_to_linear(px.srgb_g);
      res.lin_b = srgb_to_linear(px.srgb_b);
      res.luma  = rec709_luma(res.lin_r, res.lin_g, res.lin_b);
    end else begin
      res.srgb_r = linear_to_srgb(px.lin_r);
      res.srgb_g = linear_to_srgb(px.lin_g);
      res.srgb_b = linear_to_srgb(px.lin_b);
      res.luma   = rec709_luma((px.lin_r > LIN_FULL) ? int'(LIN_FULL) : px.lin_r,
                               (px.lin_g > LIN_FULL) ? int'(LIN_FULL) : px.lin_g,
                               (px.lin_b > LIN_FULL) ? int'(LIN_FULL) : px.lin_b);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // linear codes weighted towards the knee, the dark end and full scale
  function automatic logic [FIELD_W-1:0] random_linear();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return FIELD_W'($urandom_range(0, 65535));
    if (sel <= 7) return FIELD_W'($urandom_range(0, 600));
    if (sel == 8) return FIELD_W'($urandom_range(65000, 65535));
    return FIELD_W'($urandom_range(195, 215));
  endfunction

  function automatic pixel_in_t random_pixel(pixel_cmd_e mode);
    pixel_in_t px;
    px.cmd    = mode;
    px.srgb_r = SRGB_W'($urandom_range(0, 255));
    px.srgb_g = SRGB_W'($urandom_range(0, 255));
    px.srgb_b = SRGB_W'($urandom_range(0, 255));
    px.lin_r  = random_linear();
    px.lin_g  = random_linear();
    px.lin_b  = random_linear();
    return px;
  endfunction

  // used channels set explicitly, unused ones left random
  function automatic pixel_in_t directed_pixel(pixel_cmd_e mode, int unsigned r,
                                               int unsigned g, int unsigned b);
    pixel_in_t px;
    px = random_pixel(mode);
    if (mode == CMD_DECODE) begin
      px.srgb_r = SRGB_W'(r);
      px.srgb_g = SRGB_W'(g);
      px.srgb_b = SRGB_W'(b);
    end else begin
      px.lin_r = FIELD_W'(r);
      px.lin_g = FIELD_W'(g);
      px.lin_b = FIELD_W'(b);
    end
    return px;
  endfunction

  task automatic send_pixel(pixel_in_t px);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd        <= px.cmd;
    srgb_red   <= px.srgb_r;
    srgb_green <= px.srgb_g;
    srgb_blue  <= px.srgb_b;
    lin_red    <= px.lin_r;
    lin_green  <= px.lin_g;
    lin_blue   <= px.lin_b;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(predict_pixel(px));
  endtask

  task automatic test_decode_curve();
    send_pixel(directed_pixel(CMD_DECODE, 0, 0, 0));
    send_pixel(directed_pixel(CMD_DECODE, 10, 11, 255));   // either side of the knee
    send_pixel(directed_pixel(CMD_DECODE, 255, 255, 255)); // white, luminance saturates
    send_pixel(directed_pixel(CMD_DECODE, 1, 9, 12));
    send_pixel(directed_pixel(CMD_DECODE, 11, 10, 0));
    send_pixel(directed_pixel(CMD_DECODE, 128, 64, 200));
    send_pixel(directed_pixel(CMD_DECODE, 254, 85, 170));
    send_pixel(directed_pixel(CMD_DECODE, 255, 0, 0));
    send_pixel(directed_pixel(CMD_DECODE, 0, 255, 0));
    send_pixel(directed_pixel(CMD_DECODE, 0, 0, 255));
  endtask

  task automatic test_encode_curve();
    send_pixel(directed_pixel(CMD_ENCODE, 0, 0, 0));
    send_pixel(directed_pixel(CMD_ENCODE, 205, 206, 1));   // last linear code and first curve code
    send_pixel(directed_pixel(CMD_ENCODE, 65535, 65535, 65535));
    send_pixel(directed_pixel(CMD_ENCODE, 65534, 204, 207));
    send_pixel(directed_pixel(CMD_ENCODE, 65535, 0, 0));
    send_pixel(directed_pixel(CMD_ENCODE, 0, 65535, 0));
    send_pixel(directed_pixel(CMD_ENCODE, 0, 0, 65535));
    send_pixel(directed_pixel(CMD_ENCODE, 32768, 16384, 4096));
    send_pixel(directed_pixel(CMD_ENCODE, 16'hAAAA, 16'h5555, 206));
    send_pixel(directed_pixel(CMD_ENCODE, 206, 205, 2));
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (100) send_pixel(random_pixel(pixel_cmd_e'($urandom_range(0, 1))));
    no_gaps = 1'b0;
  endtask

  task automatic test_random_mix();
    repeat (700) send_pixel(random_pixel(pixel_cmd_e'($urandom_range(0, 1))));
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_failure(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_failure($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin : check_result
    pixel_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_failure("result with no pending transaction");
      end else begin
        want = expected_pixels.pop_front();
        compare_field("mode_echo", mode_echo, want.mode);
        compare_field("out_lin_red", out_lin_red, want.lin_r);
        compare_field("out_lin_green", out_lin_green, want.lin_g);
        compare_field("out_lin_blue", out_lin_blue, want.lin_b);
        compare_field("out_srgb_red", out_srgb_red, want.srgb_r);
        compare_field("out_srgb_green", out_srgb_green, want.srgb_g);
        compare_field("out_srgb_blue", out_srgb_blue, want.srgb_b);
        compare_field("luminance", luminance, want.luma);
      end
    end
  end

  // sink: stall for a random number of cycles before each result
  initial begin : sink_stall
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    fail_count  = 0;
    cycle_count = 0;
    no_gaps     = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    cmd        <= 1'b0;
    srgb_red   <= '0;
    srgb_green <= '0;
    srgb_blue  <= '0;
    lin_red    <= '0;
    lin_green  <= '0;
    lin_blue   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_decode_curve();
    test_encode_curve();
    test_back_to_back();
    test_random_mix();

    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
